// ===== src/clns_pkg.sv =====
// Shared constants, control word layout and status types for the LCD nibble sequencer.
package clns_pkg;

    // Decimal digits kept for a number request
    localparam int MAX_DIGITS  = 10;
    localparam int DIGIT_CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int DIGIT_IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    // Microprogram addressing
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_IDLE  = 5'd0;
    localparam logic [STEP_W-1:0] ENTRY_INIT = 5'd1;
    localparam logic [STEP_W-1:0] ENTRY_CMD  = 5'd15;
    localparam logic [STEP_W-1:0] ENTRY_DATA = 5'd17;
    localparam logic [STEP_W-1:0] ENTRY_NUM  = 5'd19;
    localparam logic [STEP_W-1:0] STEP_POP   = 5'd20;

    // Request kinds
    localparam logic [2:0] KIND_INIT    = 3'd0;
    localparam logic [2:0] KIND_COMMAND = 3'd1;
    localparam logic [2:0] KIND_DATA    = 3'd2;
    localparam logic [2:0] KIND_CURSOR  = 3'd3;
    localparam logic [2:0] KIND_NUMBER  = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_COMMAND_WAIT = 2'd0;
    localparam logic [1:0] CFG_SHORT_WAIT   = 2'd1;
    localparam logic [1:0] CFG_DATA_WAIT    = 2'd2;

    // Reset values of the wait registers
    localparam logic [7:0] COMMAND_WAIT_RST = 8'd60;
    localparam logic [7:0] SHORT_WAIT_RST   = 8'd2;
    localparam logic [7:0] DATA_WAIT_RST    = 8'd60;

    // LCD command codes and address bases
    localparam logic [7:0] CMD_CLEAR      = 8'h01;
    localparam logic [7:0] CMD_HOME       = 8'h02;
    localparam logic [7:0] CMD_FUNC_SET   = 8'h28;
    localparam logic [7:0] CMD_DISP_OFF   = 8'h08;
    localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
    localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;
    localparam logic [7:0] ROW0_BASE      = 8'h80;
    localparam logic [7:0] ROW1_BASE      = 8'hC0;
    localparam logic [7:0] ASCII_ZERO     = 8'h30;

    // Fixed waits of the init sequence
    localparam logic [5:0] INIT_PRE_WAIT = 6'd40;
    localparam logic [7:0] WAIT_FIVE     = 8'd5;
    localparam logic [7:0] WAIT_HUNDRED  = 8'd100;

    // Divide by ten: q = (n * RECIP10) >> RECIP_SHIFT, exact for 32-bit n
    localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    // Control word fields
    typedef enum logic [1:0] {
        NS_LIT,
        NS_HI,
        NS_LO
    } nib_sel_t;

    typedef enum logic [2:0] {
        POST_NONE,
        POST_FIVE,
        POST_HUNDRED,
        POST_COMMAND,
        POST_DATA
    } post_sel_t;

    typedef enum logic [1:0] {
        BL_NONE,
        BL_LIT,
        BL_DIGIT
    } byte_sel_t;

    typedef enum logic [1:0] {
        LAST_NO,
        LAST_YES,
        LAST_EMPTY
    } last_sel_t;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_END,
        JMP_WAIT,
        JMP_LOOP
    } jump_t;

    typedef struct packed {
        logic              emit;
        nib_sel_t          nib_sel;
        logic [3:0]        lit_nib;
        logic              rs;
        logic              pre_init;
        post_sel_t         post_sel;
        byte_sel_t         byte_sel;
        logic [7:0]        lit_byte;
        last_sel_t         last_sel;
        jump_t             jump;
        logic [STEP_W-1:0] target;
    } ctrl_word_t;

    // Sequencer to digit unit
    typedef struct packed {
        logic start;
        logic pop;
    } digit_ctrl_t;

    // Digit unit to sequencer
    typedef struct packed {
        logic       busy;
        logic       has_digit;
        logic [3:0] digit;
    } digit_status_t;

endpackage

// ===== src/clns_ucode_rom.sv =====
// Microprogram table of the LCD nibble sequencer.
module clns_ucode_rom
(
    input  logic [clns_pkg::STEP_W-1:0] addr,
    output clns_pkg::ctrl_word_t        word
);

    // Build one control word
    function automatic clns_pkg::ctrl_word_t cw(
        input logic                        emit,
        input clns_pkg::nib_sel_t          nib_sel,
        input logic [3:0]                  lit_nib,
        input logic                        rs,
        input logic                        pre_init,
        input clns_pkg::post_sel_t         post_sel,
        input clns_pkg::byte_sel_t         byte_sel,
        input logic [7:0]                  lit_byte,
        input clns_pkg::last_sel_t         last_sel,
        input clns_pkg::jump_t             jump,
        input logic [clns_pkg::STEP_W-1:0] target
    );
        clns_pkg::ctrl_word_t w;
        w.emit     = emit;
        w.nib_sel  = nib_sel;
        w.lit_nib  = lit_nib;
        w.rs       = rs;
        w.pre_init = pre_init;
        w.post_sel = post_sel;
        w.byte_sel = byte_sel;
        w.lit_byte = lit_byte;
        w.last_sel = last_sel;
        w.jump     = jump;
        w.target   = target;
        return w;
    endfunction

    // Program: init, command, data, number entries
    always_comb
    begin
        unique case (addr)
            // init: three 0x3 wake-ups and the switch to 4-bit mode
            5'd1:  word = cw(1'b1, clns_pkg::NS_LIT, 4'h3, 1'b0, 1'b1, clns_pkg::POST_FIVE,
                             clns_pkg::BL_NONE, 8'h00, clns_pkg::LAST_NO, clns_pkg::JMP_NEXT,
                             clns_pkg::STEP_IDLE);
            5'd2:  word = cw(1'b1, clns_pkg::NS_LIT, 4'h3, 1'b0, 1'b0, clns_pkg::POST_HUNDRED,
                             clns_pkg::BL_NONE, 8'h00, clns_pkg::LAST_NO, clns_pkg::JMP_NEXT,
                             clns_pkg::STEP_IDLE);
            5'd3:  word = cw(1'b1, clns_pkg::NS_LIT, 4'h3, 1'b0, 1'b0, clns_pkg::POST_HUNDRED,
                             clns_pkg::BL_NONE, 8'h00, clns_pkg::LAST_NO, clns_pkg::JMP_NEXT,
                             clns_pkg::STEP_IDLE);
            5'd4:  word = cw(1'b1, clns_pkg::NS_LIT, 4'h2, 1'b0, 1'b0, clns_pkg::POST_HUNDRED,
                             clns_pkg::BL_LIT, clns_pkg::CMD_FUNC_SET, clns_pkg::LAST_NO,
                             clns_pkg::JMP_NEXT, clns_pkg::STEP_IDLE);
            // init: five command bytes
            5'd5, 5'd7, 5'd9, 5'd11, 5'd13:
                   word = cw(1'b1, clns_pkg::NS_HI, 4'h0, 1'b0, 1'b0, clns_pkg::POST_NONE,
                             clns_pkg::BL_NONE, 8'h00, clns_pkg::LAST_NO, clns_pkg::JMP_NEXT,
                             clns_pkg::STEP_IDLE);
            5'd6:  word = cw(1'b1, clns_pkg::NS_LO, 4'h0, 1'b0, 1'b0, clns_pkg::POST_COMMAND,
                             clns_pkg::BL_LIT, clns_pkg::CMD_DISP_OFF, clns_pkg::LAST_NO,
                             clns_pkg::JMP_NEXT, clns_pkg::STEP_IDLE);
            5'd8:  word = cw(1'b1, clns_pkg::NS_LO, 4'h0, 1'b0, 1'b0, clns_pkg::POST_COMMAND,
                             clns_pkg::BL_LIT, clns_pkg::CMD_CLEAR, clns_pkg::LAST_NO,
                             clns_pkg::JMP_NEXT, clns_pkg::STEP_IDLE);
            5'd10: word = cw(1'b1, clns_pkg::NS_LO, 4'h0, 1'b0, 1'b0, clns_pkg::POST_COMMAND,
                             clns_pkg::BL_LIT, clns_pkg::CMD_ENTRY_MODE, clns_pkg::LAST_NO,
                             clns_pkg::JMP_NEXT, clns_pkg::STEP_IDLE);
            5'd12: word = cw(1'b1, clns_pkg::NS_LO, 4'h0, 1'b0, 1'b0, clns_pkg::POST_COMMAND,
                             clns_pkg::BL_LIT, clns_pkg::CMD_DISPLAY_ON, clns_pkg::LAST_NO,
                             clns_pkg::JMP_NEXT, clns_pkg::STEP_IDLE);
            5'd14: word = cw(1'b1, clns_pkg::NS_LO, 4'h0, 1'b0, 1'b0, clns_pkg::POST_COMMAND,
                             clns_pkg::BL_NONE, 8'h00, clns_pkg::LAST_YES, clns_pkg::JMP_END,
                             clns_pkg::STEP_IDLE);
            // command byte (also cursor)
            5'd15: word = cw(1'b1, clns_pkg::NS_HI, 4'h0, 1'b0, 1'b0, clns_pkg::POST_NONE,
                             clns_pkg::BL_NONE, 8'h00, clns_pkg::LAST_NO, clns_pkg::JMP_NEXT,
                             clns_pkg::STEP_IDLE);
            5'd16: word = cw(1'b1, clns_pkg::NS_LO, 4'h0, 1'b0, 1'b0, clns_pkg::POST_COMMAND,
                             clns_pkg::BL_NONE, 8'h00, clns_pkg::LAST_YES, clns_pkg::JMP_END,
                             clns_pkg::STEP_IDLE);
            // data byte
            5'd17: word = cw(1'b1, clns_pkg::NS_HI, 4'h0, 1'b1, 1'b0, clns_pkg::POST_NONE,
                             clns_pkg::BL_NONE, 8'h00, clns_pkg::LAST_NO, clns_pkg::JMP_NEXT,
                             clns_pkg::STEP_IDLE);
            5'd18: word = cw(1'b1, clns_pkg::NS_LO, 4'h0, 1'b1, 1'b0, clns_pkg::POST_DATA,
                             clns_pkg::BL_NONE, 8'h00, clns_pkg::LAST_YES, clns_pkg::JMP_END,
                             clns_pkg::STEP_IDLE);
            // number: wait for conversion, then pop and send digits
            5'd19: word = cw(1'b0, clns_pkg::NS_LIT, 4'h0, 1'b0, 1'b0, clns_pkg::POST_NONE,
                             clns_pkg::BL_NONE, 8'h00, clns_pkg::LAST_NO, clns_pkg::JMP_WAIT,
                             clns_pkg::STEP_IDLE);
            5'd20: word = cw(1'b0, clns_pkg::NS_LIT, 4'h0, 1'b0, 1'b0, clns_pkg::POST_NONE,
                             clns_pkg::BL_DIGIT, 8'h00, clns_pkg::LAST_NO, clns_pkg::JMP_NEXT,
                             clns_pkg::STEP_IDLE);
            5'd21: word = cw(1'b1, clns_pkg::NS_HI, 4'h0, 1'b1, 1'b0, clns_pkg::POST_NONE,
                             clns_pkg::BL_NONE, 8'h00, clns_pkg::LAST_NO, clns_pkg::JMP_NEXT,
                             clns_pkg::STEP_IDLE);
            5'd22: word = cw(1'b1, clns_pkg::NS_LO, 4'h0, 1'b1, 1'b0, clns_pkg::POST_DATA,
                             clns_pkg::BL_NONE, 8'h00, clns_pkg::LAST_EMPTY, clns_pkg::JMP_LOOP,
                             clns_pkg::STEP_POP);
            // idle and unused addresses
            default:
                   word = cw(1'b0, clns_pkg::NS_LIT, 4'h0, 1'b0, 1'b0, clns_pkg::POST_NONE,
                             clns_pkg::BL_NONE, 8'h00, clns_pkg::LAST_NO, clns_pkg::JMP_END,
                             clns_pkg::STEP_IDLE);
        endcase
    end

endmodule

// ===== src/clns_digit_unit.sv =====
// Binary to decimal digit converter with a digit stack; each digit takes a multiply phase and a subtract phase.
module clns_digit_unit
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  clns_pkg::digit_ctrl_t   ctrl,
    input  logic [31:0]             number,
    output clns_pkg::digit_status_t status
);

    typedef enum logic {
        PH_MUL,
        PH_SUB
    } phase_t;

    phase_t                             phase_reg;
    logic                               busy_reg;
    logic [clns_pkg::DIGIT_CNT_W-1:0]   cnt_reg;
    logic [31:0]                        num_reg;
    logic [63:0]                        prod_reg;
    logic [3:0]                         digit_reg [clns_pkg::MAX_DIGITS];

    logic [31:0]                        quot;
    logic [31:0]                        quot_x10;
    logic [31:0]                        rem;
    logic                               conv_done;
    logic [clns_pkg::DIGIT_CNT_W-1:0]   cnt_dec;

    // Quotient from the reciprocal product, remainder by shift-add
    assign quot      = {3'b000, prod_reg[63:clns_pkg::RECIP_SHIFT]};
    assign quot_x10  = (quot << 3) + (quot << 1);
    assign rem       = num_reg - quot_x10;
    assign conv_done = (quot == 32'd0) ||
                       (cnt_reg == clns_pkg::DIGIT_CNT_W'(clns_pkg::MAX_DIGITS - 1));
    assign cnt_dec   = cnt_reg - clns_pkg::DIGIT_CNT_W'(1);

    assign status.busy      = busy_reg;
    assign status.has_digit = (cnt_reg != '0);
    assign status.digit     = digit_reg[cnt_dec[clns_pkg::DIGIT_IDX_W-1:0]];

    // Control: phase, busy and stack depth
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_MUL;
            busy_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else if (ctrl.start)
        begin
            phase_reg <= PH_MUL;
            busy_reg  <= 1'b1;
            cnt_reg   <= '0;
        end
        else if (busy_reg)
        begin
            unique case (phase_reg)
                PH_MUL:
                begin
                    phase_reg <= PH_SUB;
                end
                PH_SUB:
                begin
                    phase_reg <= PH_MUL;
                    cnt_reg   <= cnt_reg + clns_pkg::DIGIT_CNT_W'(1);
                    if (conv_done)
                    begin
                        busy_reg <= 1'b0;
                    end
                end
                default:
                begin
                    phase_reg <= PH_MUL;
                end
            endcase
        end
        else if (ctrl.pop)
        begin
            cnt_reg <= cnt_dec;
        end
    end

    // Datapath: working value, product and digit stack
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            num_reg <= number;
        end
        else if (busy_reg && phase_reg == PH_MUL)
        begin
            prod_reg <= {32'd0, num_reg} * {32'd0, clns_pkg::RECIP10};
        end
        else if (busy_reg && phase_reg == PH_SUB)
        begin
            num_reg <= quot;
            digit_reg[cnt_reg[clns_pkg::DIGIT_IDX_W-1:0]] <= rem[3:0];
        end
    end

`ifndef SYNTHESIS
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.pop |-> (cnt_reg != '0) && !busy_reg)
        else $error("digit pop from an empty or busy stack");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= clns_pkg::DIGIT_CNT_W'(clns_pkg::MAX_DIGITS))
        else $error("digit stack deeper than its size");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |-> !busy_reg && (cnt_reg == '0))
        else $error("conversion started while digits remain");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && phase_reg == PH_SUB) |-> (rem < 32'd10))
        else $error("decimal remainder out of range");
`endif

endmodule

// ===== src/char_lcd_nibble_sequencer.sv =====
// Top level of the character LCD nibble sequencer: step counter, datapath and output register.
//
// Turns one request (init, command, data byte, cursor, number) into a run of 4-bit LCD
// strobes, each with a register-select flag, a wait before and a wait after it, and tlast
// on the final strobe. A microprogram steps once per cycle unless a sink stall or a pending
// digit conversion holds it, and issues at most one strobe a cycle into a single output
// register. A number request first runs the divide-by-ten loop (one multiply and one subtract
// per digit), then pops the digits and sends each as a data byte. A new request is taken once
// the previous one has placed its last strobe in the output register; sink stalls only hold
// the program. Kinds 5 to 7 produce no strobes. Wait registers are written through
// cfg_we/cfg_index/cfg_data; the user must do so only while the block is idle (not enforced).
module char_lcd_nibble_sequencer
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // byte_value[7:0], column[13:8], row[14], number[46:15]
    input  logic [2:0]  s_tuser,   // kind[2:0]
    // strobe stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // nibble[3:0], pre_wait_ms[9:4], post_wait_ms[17:10]
    output logic        m_tuser,   // register_select[0]
    output logic        m_tlast
);

    logic [clns_pkg::STEP_W-1:0] step_reg;
    logic [clns_pkg::STEP_W-1:0] step_next;
    logic [7:0]                  byte_reg;
    logic [7:0]                  byte_next;
    logic [7:0]                  cmd_wait_reg;
    logic [7:0]                  short_wait_reg;
    logic [7:0]                  data_wait_reg;

    logic                        out_valid_reg;
    logic [3:0]                  out_nib_reg;
    logic                        out_rs_reg;
    logic [5:0]                  out_pre_reg;
    logic [7:0]                  out_post_reg;
    logic                        out_last_reg;

    clns_pkg::ctrl_word_t        word;
    clns_pkg::digit_ctrl_t       dctrl;
    clns_pkg::digit_status_t     dstat;

    logic                        active;
    logic                        accept;
    logic                        can_emit;
    logic                        go;
    logic                        emit_fire;
    logic [7:0]                  cursor_addr;
    logic [3:0]                  nib_val;
    logic [5:0]                  pre_val;
    logic [7:0]                  post_val;
    logic                        last_val;

    clns_ucode_rom u_rom
    (
        .addr (step_reg),
        .word (word)
    );

    clns_digit_unit u_digits
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (dctrl),
        .number (s_tdata[46:15]),
        .status (dstat)
    );

    assign active      = (step_reg != clns_pkg::STEP_IDLE);
    assign s_tready    = !active;
    assign accept      = s_tvalid && !active;
    assign can_emit    = !out_valid_reg || m_tready;
    assign cursor_addr = (s_tdata[14] ? clns_pkg::ROW1_BASE : clns_pkg::ROW0_BASE)
                         + {2'b00, s_tdata[13:8]};

    // Sequencer: dispatch on request kind, then follow the program
    always_comb
    begin
        step_next = step_reg;
        go        = 1'b0;
        if (!active)
        begin
            if (s_tvalid)
            begin
                unique case (s_tuser)
                    clns_pkg::KIND_INIT:    step_next = clns_pkg::ENTRY_INIT;
                    clns_pkg::KIND_COMMAND: step_next = clns_pkg::ENTRY_CMD;
                    clns_pkg::KIND_CURSOR:  step_next = clns_pkg::ENTRY_CMD;
                    clns_pkg::KIND_DATA:    step_next = clns_pkg::ENTRY_DATA;
                    clns_pkg::KIND_NUMBER:  step_next = clns_pkg::ENTRY_NUM;
                    default:                step_next = clns_pkg::STEP_IDLE;
                endcase
            end
        end
        else
        begin
            go = !word.emit || can_emit;
            case (word.jump)
                clns_pkg::JMP_NEXT:
                begin
                    if (go)
                    begin
                        step_next = step_reg + clns_pkg::STEP_W'(1);
                    end
                end
                clns_pkg::JMP_END:
                begin
                    if (go)
                    begin
                        step_next = clns_pkg::STEP_IDLE;
                    end
                end
                clns_pkg::JMP_WAIT:
                begin
                    go = !dstat.busy;
                    if (go)
                    begin
                        step_next = step_reg + clns_pkg::STEP_W'(1);
                    end
                end
                clns_pkg::JMP_LOOP:
                begin
                    if (go)
                    begin
                        step_next = dstat.has_digit ? word.target : clns_pkg::STEP_IDLE;
                    end
                end
                default:
                begin
                    step_next = clns_pkg::STEP_IDLE;
                end
            endcase
        end
    end

    assign emit_fire   = active && word.emit && go;
    assign dctrl.start = accept && (s_tuser == clns_pkg::KIND_NUMBER);
    assign dctrl.pop   = active && go && (word.byte_sel == clns_pkg::BL_DIGIT);

    // Working byte: request byte or cursor address, program literal or popped digit
    always_comb
    begin
        byte_next = byte_reg;
        if (accept)
        begin
            byte_next = (s_tuser == clns_pkg::KIND_CURSOR) ? cursor_addr : s_tdata[7:0];
        end
        else if (active && go)
        begin
            case (word.byte_sel)
                clns_pkg::BL_LIT:   byte_next = word.lit_byte;
                clns_pkg::BL_DIGIT: byte_next = clns_pkg::ASCII_ZERO + {4'h0, dstat.digit};
                default:            byte_next = byte_reg;
            endcase
        end
    end

    // Strobe fields from the control word
    always_comb
    begin
        case (word.nib_sel)
            clns_pkg::NS_HI: nib_val = byte_reg[7:4];
            clns_pkg::NS_LO: nib_val = byte_reg[3:0];
            default:         nib_val = word.lit_nib;
        endcase

        case (word.post_sel)
            clns_pkg::POST_FIVE:    post_val = clns_pkg::WAIT_FIVE;
            clns_pkg::POST_HUNDRED: post_val = clns_pkg::WAIT_HUNDRED;
            clns_pkg::POST_COMMAND:
            begin
                post_val = (byte_reg == clns_pkg::CMD_CLEAR || byte_reg == clns_pkg::CMD_HOME)
                           ? short_wait_reg : cmd_wait_reg;
            end
            clns_pkg::POST_DATA:    post_val = data_wait_reg;
            default:                post_val = 8'd0;
        endcase

        case (word.last_sel)
            clns_pkg::LAST_YES:   last_val = 1'b1;
            clns_pkg::LAST_EMPTY: last_val = !dstat.has_digit;
            default:              last_val = 1'b0;
        endcase

        pre_val = word.pre_init ? clns_pkg::INIT_PRE_WAIT : 6'd0;
    end

    // Control registers: step, wait settings, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= clns_pkg::STEP_IDLE;
            cmd_wait_reg   <= clns_pkg::COMMAND_WAIT_RST;
            short_wait_reg <= clns_pkg::SHORT_WAIT_RST;
            data_wait_reg  <= clns_pkg::DATA_WAIT_RST;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    clns_pkg::CFG_COMMAND_WAIT: cmd_wait_reg   <= cfg_data;
                    clns_pkg::CFG_SHORT_WAIT:   short_wait_reg <= cfg_data;
                    clns_pkg::CFG_DATA_WAIT:    data_wait_reg  <= cfg_data;
                    default:                    ;
                endcase
            end
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        if (emit_fire)
        begin
            out_nib_reg  <= nib_val;
            out_rs_reg   <= word.rs;
            out_pre_reg  <= pre_val;
            out_post_reg <= post_val;
            out_last_reg <= last_val;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_post_reg, out_pre_reg, out_nib_reg};
    assign m_tuser  = out_rs_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && last_val) |=> (step_reg == clns_pkg::STEP_IDLE))
        else $error("program still running after the last strobe");

    a_pre_wait_instr: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[9:4] != 6'd0) |-> (m_tuser == 1'b0))
        else $error("pre wait on a data register strobe");

    a_idle_stack_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == clns_pkg::STEP_IDLE) |-> (!dstat.busy && !dstat.has_digit))
        else $error("digits left over at the end of a request");
`endif

endmodule

// ===== dv/char_lcd_nibble_sequencer_tb.sv =====
// Self-checking testbench for the character LCD nibble sequencer: request driver, strobe monitor.
module char_lcd_nibble_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 100;
    localparam int PHASE_ITEMS  = 61;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  byte_value;
        logic [5:0]  column;
        logic        row;
        logic [31:0] number;
    } lcd_req_t;

    typedef struct packed {
        logic [3:0] nibble;
        logic       rs;
        logic [5:0] pre_wait;
        logic [7:0] post_wait;
        logic       last;
    } strobe_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;   // byte_value[7:0], column[13:8], row[14], number[46:15]
    logic [2:0]  s_tuser = '0;   // kind[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // nibble[3:0], pre_wait_ms[9:4], post_wait_ms[17:10]
    logic        m_tuser;        // register_select[0]
    logic        m_tlast;

    // Mirror of the wait registers
    logic [7:0] cmd_wait   = clns_pkg::COMMAND_WAIT_RST;
    logic [7:0] short_wait = clns_pkg::SHORT_WAIT_RST;
    logic [7:0] data_wait  = clns_pkg::DATA_WAIT_RST;

    lcd_req_t   req_backlog[$];
    strobe_t    pending_strobes[$];
    strobe_t    run_strobes[$];
    lcd_req_t   cur_req;
    int         req_total = 0;
    int         req_done = 0;
    int         fail_count = 0;
    int         cycle_cnt = 0;
    idle_mode_t idle_mode = IDLE_NONE;

    char_lcd_nibble_sequencer dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Strobe builders for the predictor
    task automatic add_strobe(input logic [3:0] nib, input logic rs, input logic [5:0] pre,
                              input logic [7:0] post);
        strobe_t s;
        s.nibble    = nib;
        s.rs        = rs;
        s.pre_wait  = pre;
        s.post_wait = post;
        s.last      = 1'b0;
        run_strobes.push_back(s);
    endtask

    task automatic add_byte(input logic [7:0] b, input logic rs, input logic [7:0] post);
        add_strobe(b[7:4], rs, 6'd0, 8'd0);
        add_strobe(b[3:0], rs, 6'd0, post);
    endtask

    task automatic add_command(input logic [7:0] b);
        add_byte(b, 1'b0, (b == clns_pkg::CMD_CLEAR || b == clns_pkg::CMD_HOME)
                          ? short_wait : cmd_wait);
    endtask

    // Expected strobe run of one accepted request
    task automatic build_strobes(input lcd_req_t r);
        logic [3:0]  digits[20];
        logic [31:0] n;
        int          cnt;
        run_strobes.delete();
        case (r.kind)
            clns_pkg::KIND_INIT:
            begin
                add_strobe(4'h3, 1'b0, clns_pkg::INIT_PRE_WAIT, clns_pkg::WAIT_FIVE);
                add_strobe(4'h3, 1'b0, 6'd0, clns_pkg::WAIT_HUNDRED);
                add_strobe(4'h3, 1'b0, 6'd0, clns_pkg::WAIT_HUNDRED);
                add_strobe(4'h2, 1'b0, 6'd0, clns_pkg::WAIT_HUNDRED);
                add_command(clns_pkg::CMD_FUNC_SET);
                add_command(clns_pkg::CMD_DISP_OFF);
                add_command(clns_pkg::CMD_CLEAR);
                add_command(clns_pkg::CMD_ENTRY_MODE);
                add_command(clns_pkg::CMD_DISPLAY_ON);
            end
            clns_pkg::KIND_COMMAND: add_command(r.byte_value);
            clns_pkg::KIND_DATA:    add_byte(r.byte_value, 1'b1, data_wait);
            clns_pkg::KIND_CURSOR:
                add_command(8'((r.row ? clns_pkg::ROW1_BASE : clns_pkg::ROW0_BASE)
                               + {2'b00, r.column}));
            clns_pkg::KIND_NUMBER:
            begin
                n = r.number;
                cnt = 0;
                if (n == 0)
                begin
                    digits[0] = 4'd0;
                    cnt = 1;
                end
                else
                begin
                    // only the low MAX_DIGITS digits survive
                    while (n != 0 && cnt < clns_pkg::MAX_DIGITS)
                    begin
                        digits[cnt] = 4'(n % 10);
                        n = n / 10;
                        cnt++;
                    end
                end
                for (int i = cnt - 1; i >= 0; i--)
                    add_byte(clns_pkg::ASCII_ZERO + {4'd0, digits[i]}, 1'b1, data_wait);
            end
            default: ;  // unused kinds send nothing
        endcase
        if (run_strobes.size() != 0)
            run_strobes[run_strobes.size() - 1].last = 1'b1;
        foreach (run_strobes[i])
            pending_strobes.push_back(run_strobes[i]);
    endtask

    function automatic logic sender_idles();
        if (idle_mode == IDLE_SEND)
            return $urandom_range(0, 99) < 51;
        if (idle_mode == IDLE_BOTH)
            return $urandom_range(0, 99) < 19;
        return 1'b0;
    endfunction

    function automatic logic receiver_stalls();
        if (idle_mode == IDLE_RECV)
            return $urandom_range(0, 99) < 51;
        if (idle_mode == IDLE_BOTH)
            return $urandom_range(0, 99) < 19;
        return 1'b0;
    endfunction

    // Request driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                build_strobes(cur_req);
                req_done++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (req_backlog.size() != 0 && !sender_idles())
                begin
                    cur_req = req_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {1'b0, cur_req.number, cur_req.row, cur_req.column,
                                 cur_req.byte_value};
                    s_tuser  <= cur_req.kind;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Strobe monitor and sink backpressure
    always @(posedge clk)
    begin : strobe_mon
        strobe_t got;
        strobe_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.nibble    = m_tdata[3:0];
                got.rs        = m_tuser;
                got.pre_wait  = m_tdata[9:4];
                got.post_wait = m_tdata[17:10];
                got.last      = m_tlast;
                if (pending_strobes.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: unexpected strobe nib=%h rs=%b pre=%0d post=%0d last=%b",
                                 $realtime, got.nibble, got.rs, got.pre_wait, got.post_wait,
                                 got.last);
                    fail_count++;
                end
                else
                begin
                    want = pending_strobes.pop_front();
                    if (got.nibble !== want.nibble || got.rs !== want.rs ||
                        got.pre_wait !== want.pre_wait || got.post_wait !== want.post_wait ||
                        got.last !== want.last)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("%0t: expected nib=%h rs=%b pre=%0d post=%0d last=%b",
                                     $realtime, want.nibble, want.rs, want.pre_wait,
                                     want.post_wait, want.last);
                            $display("%0t: actual   nib=%h rs=%b pre=%0d post=%0d last=%b",
                                     $realtime, got.nibble, got.rs, got.pre_wait,
                                     got.post_wait, got.last);
                        end
                        fail_count++;
                    end
                end
            end
            m_tready <= !receiver_stalls();
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic queue_req(input logic [2:0] kind, input logic [7:0] b, input logic [5:0] col,
                             input logic row, input logic [31:0] num);
        lcd_req_t r;
        r.kind       = kind;
        r.byte_value = b;
        r.column     = col;
        r.row        = row;
        r.number     = num;
        req_backlog.push_back(r);
        req_total++;
    endtask

    // Random request, mostly well-formed kinds with random payload
    task automatic queue_random_req(output logic counted);
        int          pick;
        logic [2:0]  kind;
        logic [7:0]  b;
        logic [5:0]  col;
        logic [31:0] num;
        pick = $urandom_range(0, 99);
        b    = 8'($urandom());
        col  = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(40, 63))
                                           : 6'($urandom_range(0, 39));
        case ($urandom_range(0, 9))
            0:       num = 32'd0;
            1:       num = 32'hFFFF_FFFF;
            2, 3, 4: num = 32'($urandom_range(0, 999));
            default: num = $urandom() >> $urandom_range(0, 28);
        endcase
        if (pick < 4)
            kind = clns_pkg::KIND_INIT;
        else if (pick < 30)
        begin
            kind = clns_pkg::KIND_COMMAND;
            if ($urandom_range(0, 9) == 0)
                b = $urandom_range(0, 1) ? clns_pkg::CMD_CLEAR : clns_pkg::CMD_HOME;
        end
        else if (pick < 55)
            kind = clns_pkg::KIND_DATA;
        else if (pick < 75)
            kind = clns_pkg::KIND_CURSOR;
        else if (pick < 95)
            kind = clns_pkg::KIND_NUMBER;
        else
            kind = 3'(clns_pkg::KIND_NUMBER + $urandom_range(1, 3));
        queue_req(kind, b, col, 1'($urandom()), num);
        counted = (kind <= clns_pkg::KIND_NUMBER);
    endtask

    // Wait until every request is taken and every strobe has come out
    task automatic wait_drained();
        while (req_done != req_total)
            @(posedge clk);
        while (pending_strobes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_waits(input logic [7:0] cmd_v, input logic [7:0] short_v,
                               input logic [7:0] data_v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= clns_pkg::CFG_COMMAND_WAIT;
        cfg_data  <= cmd_v;
        cmd_wait   = cmd_v;
        @(posedge clk);
        cfg_index <= clns_pkg::CFG_SHORT_WAIT;
        cfg_data  <= short_v;
        short_wait = short_v;
        @(posedge clk);
        cfg_index <= clns_pkg::CFG_DATA_WAIT;
        cfg_data  <= data_v;
        data_wait  = data_v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Stimulus sequence
    initial
    begin
        logic counted;
        int   made;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset waits
        queue_req(clns_pkg::KIND_INIT, 8'h00, 6'd0, 1'b0, 32'd0);
        queue_req(clns_pkg::KIND_COMMAND, 8'h00, 6'd0, 1'b0, 32'd0);
        queue_req(clns_pkg::KIND_COMMAND, clns_pkg::CMD_CLEAR, 6'd0, 1'b0, 32'd0);
        queue_req(clns_pkg::KIND_COMMAND, clns_pkg::CMD_HOME, 6'd0, 1'b0, 32'd0);
        queue_req(clns_pkg::KIND_COMMAND, 8'hFF, 6'd63, 1'b1, 32'hFFFF_FFFF);
        queue_req(clns_pkg::KIND_COMMAND, 8'h03, 6'd0, 1'b0, 32'd0);
        queue_req(clns_pkg::KIND_DATA, 8'h00, 6'd0, 1'b0, 32'd0);
        queue_req(clns_pkg::KIND_DATA, 8'hFF, 6'd0, 1'b0, 32'd0);
        queue_req(clns_pkg::KIND_DATA, 8'h41, 6'd0, 1'b0, 32'd0);
        queue_req(clns_pkg::KIND_CURSOR, 8'h00, 6'd0, 1'b0, 32'd0);
        queue_req(clns_pkg::KIND_CURSOR, 8'h00, 6'd39, 1'b0, 32'd0);
        queue_req(clns_pkg::KIND_CURSOR, 8'h00, 6'd0, 1'b1, 32'd0);
        queue_req(clns_pkg::KIND_CURSOR, 8'h00, 6'd39, 1'b1, 32'd0);
        queue_req(clns_pkg::KIND_CURSOR, 8'h00, 6'd63, 1'b1, 32'd0);
        queue_req(clns_pkg::KIND_CURSOR, 8'h00, 6'd63, 1'b0, 32'd0);
        // zero prints a single digit; ten-digit values fill the digit store
        queue_req(clns_pkg::KIND_NUMBER, 8'h00, 6'd0, 1'b0, 32'd0);
        queue_req(clns_pkg::KIND_NUMBER, 8'h00, 6'd0, 1'b0, 32'd9);
        queue_req(clns_pkg::KIND_NUMBER, 8'h00, 6'd0, 1'b0, 32'd10);
        queue_req(clns_pkg::KIND_NUMBER, 8'h00, 6'd0, 1'b0, 32'hFFFF_FFFF);
        queue_req(clns_pkg::KIND_NUMBER, 8'h00, 6'd0, 1'b0, 32'd1000000000);
        queue_req(clns_pkg::KIND_NUMBER, 8'h00, 6'd0, 1'b0, 32'd1234567890);
        // unused kinds must be swallowed without output
        for (int k = 1; k <= 3; k++)
            queue_req(3'(clns_pkg::KIND_NUMBER + k), 8'($urandom()), 6'($urandom()),
                      1'($urandom()), $urandom());
        queue_req(clns_pkg::KIND_INIT, 8'h00, 6'd0, 1'b0, 32'd0);
        wait_drained();

        // Random phases over wait settings and idle modes
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:       write_waits(8'd0, 8'd0, 8'd0);
                1:       write_waits(8'd255, 8'd255, 8'd255);
                2:       write_waits(8'd255, 8'd0, 8'd128);
                3:       write_waits(8'd0, 8'd255, 8'd1);
                default: write_waits(8'($urandom()), 8'($urandom()), 8'($urandom()));
            endcase
            idle_mode = idle_mode_t'(ph % 4);
            made = 0;
            while (made < PHASE_ITEMS)
            begin
                queue_random_req(counted);
                if (counted)
                    made++;
            end
            wait_drained();
            idle_mode = IDLE_NONE;
        end

        if (fail_count == 0 && pending_strobes.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/clns_pkg.sv
src/clns_ucode_rom.sv
src/clns_digit_unit.sv
src/char_lcd_nibble_sequencer.sv
dv/char_lcd_nibble_sequencer_tb.sv
